>>> rtl/hds_pkg.sv
// Package for the halftone dot screen: default sizes, register indexes and
// luma weights used by the top level. No dependencies.
package hds_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W   = 13;
  localparam int CFG_IW  = 2;
  localparam int DOT_W   = 7;
  localparam int SUM_W   = 32;
  localparam int LUMA_W  = 18;
  localparam int CNT_W   = 14;
  localparam int LIM_W   = 12;
  localparam int A_W     = 38;
  localparam int SQ_W    = 78;
  localparam int D2_W    = 14;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DOT_SIZE     = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd64;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd64;
  localparam logic [DOT_W-1:0] RST_DOT_SIZE     = 7'd8;

  localparam logic [DOT_W-1:0] DOT_MIN = 7'd2;
  localparam logic [DOT_W-1:0] DOT_MAX = 7'd100;

  localparam logic [9:0] W_FIRST  = 10'd299;
  localparam logic [9:0] W_SECOND = 10'd587;
  localparam logic [9:0] W_THIRD  = 10'd114;

  localparam logic [17:0] FULL_SCALE   = 18'd255000;
  localparam logic [18:0] DOUBLE_SCALE = 19'd510000;
  localparam logic [LIM_W-1:0] LIM_BOUND = 12'd2500;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage

>>> rtl/hds_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the cell sums and the radius limits. No dependencies.
module hds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/halftone_dot_screen.sv
// Top level of the halftone dot screen: cell luma sums, radius limits, dot output.
// Depends on hds_pkg and hds_ram.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | command, chan_first/second/third
//   out_    | output    | out_valid/out_stall | is_black, end_of_frame
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// A drain item passes S_IDLE, S_ORD and, when it produces an output pixel, S_OUT;
// a pixel item also passes S_SUM before S_ORD. An item that completes a cell also
// passes the setup states S_L0 to S_L2, two serial shift-and-add squarings, the
// divider and the limit write before S_ORD.
// Reset clears the position counters and the output valid flag; both RAMs start undefined.
// A stalled output holds the sequencer in its output step until the transfer.
module halftone_dot_screen #(
  parameter int MAX_WIDTH  = hds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [7:0]                 in_chan_first,
  input  logic [7:0]                 in_chan_second,
  input  logic [7:0]                 in_chan_third,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_is_black,
  output logic                       out_end_of_frame,
  input  logic                       cfg_we,
  input  logic [hds_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hds_pkg::CFG_W-1:0]  cfg_wdata
);
  import hds_pkg::*;

  localparam int CELLS = MAX_WIDTH / 2;
  localparam int SA_W  = $clog2(CELLS);
  localparam int LA_W  = $clog2(2 * CELLS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int HEW   = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_L0, S_L1, S_L2, S_SQA, S_SQB, S_DIV, S_LWR, S_ORD, S_OUT
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [DOT_W-1:0] ds_r;
  logic [WEW-1:0]   w_eff;
  logic [HEW-1:0]   h_eff;
  logic [DOT_W-1:0] d_eff, half;

  logic [CW-1:0]    in_col_r, out_col_r, in_bc_r, out_bc_r;
  logic [RW-1:0]    in_row_r, out_row_r, in_br_r, out_br_r;
  logic [DOT_W-1:0] in_cib_r, in_rib_r, out_cib_r, out_rib_r;
  logic             ic_r;

  logic [LUMA_W-1:0] y_r;
  logic [SUM_W-1:0]  sum_r, full_r, n_r, sum_new;
  logic [CNT_W-1:0]  cnt_r;
  logic [A_W-1:0]    b_r;
  logic [LA_W-1:0]   lim_addr_r;
  logic [SQ_W-1:0]   mc_r, acc_r, acc_nxt, a2_r, b2_r, rem_r, div_t;
  logic [A_W-1:0]    mp_r;
  logic [5:0]        step_r;
  logic [3:0]        bit_r;
  logic [LIM_W-1:0]  k_r;

  logic              out_valid_r, out_is_black_r, out_eof_r;

  logic              accept, in_last_col, in_last_row, cell_done, pending;
  logic              out_last_col, out_last_row;
  logic              sum_re, sum_we, lim_re, lim_we;
  logic [SA_W-1:0]   sum_raddr;
  logic [SUM_W-1:0]  sum_rdata;
  logic [LA_W-1:0]   lim_raddr;
  logic [LIM_W-1:0]  lim_rdata;
  logic [LUMA_W-1:0] luma;
  logic [DOT_W-1:0]  dx, dy;
  logic [D2_W-1:0]   d2;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WEW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = HEW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(fh_r);
    end
    if (ds_r < DOT_MIN) begin
      d_eff = DOT_MIN;
    end else if (ds_r > DOT_MAX) begin
      d_eff = DOT_MAX;
    end else begin
      d_eff = ds_r;
    end
    half = d_eff >> 1;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || cfg_we;
  assign luma = LUMA_W'(W_FIRST) * in_chan_first + LUMA_W'(W_SECOND) * in_chan_second
              + LUMA_W'(W_THIRD) * in_chan_third;

  assign in_last_col  = (WEW'(in_col_r) == w_eff - 1'b1);
  assign in_last_row  = (HEW'(in_row_r) == h_eff - 1'b1);
  assign out_last_col = (WEW'(out_col_r) == w_eff - 1'b1);
  assign out_last_row = (HEW'(out_row_r) == h_eff - 1'b1);
  assign cell_done = (in_rib_r == d_eff - 1'b1 || in_last_row)
                   && (in_cib_r == d_eff - 1'b1 || in_last_col);
  assign pending = ic_r || (in_br_r > out_br_r);

  assign sum_new = (in_rib_r == '0) ? SUM_W'(y_r) : sum_rdata + SUM_W'(y_r);
  assign acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
  assign div_t   = b2_r << bit_r;

  assign dx = (out_cib_r >= half) ? out_cib_r - half : half - out_cib_r;
  assign dy = (out_rib_r >= half) ? out_rib_r - half : half - out_rib_r;
  assign d2 = D2_W'(dx) * dx + D2_W'(dy) * dy;

  assign sum_re    = accept && in_command == CMD_PIXEL && !ic_r;
  assign sum_raddr = in_bc_r[SA_W-1:0];
  assign sum_we    = (state_r == S_SUM);
  assign lim_we    = (state_r == S_LWR);
  assign lim_re    = (state_r == S_ORD);
  assign lim_raddr = LA_W'(out_br_r[0] ? CELLS : 0) + LA_W'(out_bc_r[SA_W-1:0]);

  hds_ram #(.WIDTH(SUM_W), .DEPTH(CELLS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_raddr), .wdata(sum_new),
    .re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata)
  );

  hds_ram #(.WIDTH(LIM_W), .DEPTH(2 * CELLS)) u_lim_ram (
    .clk(clk), .we(lim_we), .waddr(lim_addr_r), .wdata(k_r),
    .re(lim_re), .raddr(lim_raddr), .rdata(lim_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fw_r        <= RST_FRAME_WIDTH;
      fh_r        <= RST_FRAME_HEIGHT;
      ds_r        <= RST_DOT_SIZE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_bc_r     <= '0;
      in_br_r     <= '0;
      in_cib_r    <= '0;
      in_rib_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_bc_r    <= '0;
      out_br_r    <= '0;
      out_cib_r   <= '0;
      out_rib_r   <= '0;
      ic_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT
                         || cfg_index == REG_DOT_SIZE)) begin
            unique case (cfg_index)
              REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
              REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
              default:          ds_r <= cfg_wdata[DOT_W-1:0];
            endcase
            in_col_r  <= '0;
            in_row_r  <= '0;
            in_bc_r   <= '0;
            in_br_r   <= '0;
            in_cib_r  <= '0;
            in_rib_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
            out_bc_r  <= '0;
            out_br_r  <= '0;
            out_cib_r <= '0;
            out_rib_r <= '0;
            ic_r      <= 1'b0;
          end else if (accept) begin
            y_r <= luma;
            state_r <= (in_command == CMD_PIXEL && !ic_r) ? S_SUM : S_ORD;
          end
        end
        S_SUM: begin
          sum_r      <= sum_new;
          cnt_r      <= (CNT_W'(in_rib_r) + 1'b1) * (CNT_W'(in_cib_r) + 1'b1);
          lim_addr_r <= LA_W'(in_br_r[0] ? CELLS : 0) + LA_W'(in_bc_r[SA_W-1:0]);
          if (in_last_col) begin
            in_col_r <= '0;
            in_cib_r <= '0;
            in_bc_r  <= '0;
            if (in_last_row) begin
              ic_r     <= 1'b1;
              in_row_r <= '0;
              in_rib_r <= '0;
              in_br_r  <= '0;
            end else begin
              in_row_r <= in_row_r + 1'b1;
              if (in_rib_r == d_eff - 1'b1) begin
                in_rib_r <= '0;
                in_br_r  <= in_br_r + 1'b1;
              end else begin
                in_rib_r <= in_rib_r + 1'b1;
              end
            end
          end else begin
            in_col_r <= in_col_r + 1'b1;
            if (in_cib_r == d_eff - 1'b1) begin
              in_cib_r <= '0;
              in_bc_r  <= in_bc_r + 1'b1;
            end else begin
              in_cib_r <= in_cib_r + 1'b1;
            end
          end
          state_r <= cell_done ? S_L0 : S_ORD;
        end
        S_L0: begin
          full_r  <= SUM_W'(cnt_r) * FULL_SCALE;
          b_r     <= A_W'(cnt_r) * DOUBLE_SCALE;
          state_r <= S_L1;
        end
        S_L1: begin
          n_r     <= (sum_r > full_r) ? '0 : full_r - sum_r;
          state_r <= S_L2;
        end
        S_L2: begin
          state_r <= S_SQA;
          step_r  <= '0;
          acc_r   <= '0;
          mc_r    <= SQ_W'(A_W'(n_r) * d_eff);
          mp_r    <= A_W'(n_r) * d_eff;
        end
        S_SQA, S_SQB: begin
          if (step_r == 6'(A_W - 1)) begin
            step_r <= '0;
            acc_r  <= '0;
            if (state_r == S_SQA) begin
              a2_r    <= acc_nxt;
              mc_r    <= SQ_W'(b_r);
              mp_r    <= b_r;
              state_r <= S_SQB;
            end else begin
              b2_r    <= acc_nxt;
              rem_r   <= a2_r;
              k_r     <= '0;
              bit_r   <= 4'(LIM_W - 1);
              state_r <= S_DIV;
            end
          end else begin
            acc_r  <= acc_nxt;
            mc_r   <= mc_r << 1;
            mp_r   <= mp_r >> 1;
            step_r <= step_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_t <= rem_r) begin
            rem_r      <= rem_r - div_t;
            k_r[bit_r] <= 1'b1;
          end
          bit_r <= bit_r - 1'b1;
          if (bit_r == '0) begin
            state_r <= S_LWR;
          end
        end
        S_LWR: begin
          state_r <= S_ORD;
        end
        S_ORD: begin
          state_r <= pending ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_is_black_r <= (d2 <= D2_W'(lim_rdata));
            out_eof_r      <= out_last_col && out_last_row;
            state_r        <= S_IDLE;
            if (out_last_col && out_last_row) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_bc_r   <= '0;
              in_br_r   <= '0;
              in_cib_r  <= '0;
              in_rib_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              out_bc_r  <= '0;
              out_br_r  <= '0;
              out_cib_r <= '0;
              out_rib_r <= '0;
              ic_r      <= 1'b0;
            end else if (out_last_col) begin
              out_col_r <= '0;
              out_cib_r <= '0;
              out_bc_r  <= '0;
              out_row_r <= out_row_r + 1'b1;
              if (out_rib_r == d_eff - 1'b1) begin
                out_rib_r <= '0;
                out_br_r  <= out_br_r + 1'b1;
              end else begin
                out_rib_r <= out_rib_r + 1'b1;
              end
            end else begin
              out_col_r <= out_col_r + 1'b1;
              if (out_cib_r == d_eff - 1'b1) begin
                out_cib_r <= '0;
                out_bc_r  <= out_bc_r + 1'b1;
              end else begin
                out_cib_r <= out_cib_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_black     = out_is_black_r;
  assign out_end_of_frame = out_eof_r;

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the output step");

  a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lim_we |-> k_r <= LIM_BOUND)
    else $error("radius limit above its bound");

  a_no_sum_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> !$past(ic_r))
    else $error("pixel summed after frame input was complete");

  a_pending_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && $past(state_r == S_ORD) |-> $past(pending))
    else $error("output step entered with no pending cell row");

endmodule
